@@ hw/rtl/pol_pkg.sv @@
// ----------------------------------------------------------------------------
// pol_pkg
// Shared types, codes and sizes for the positional ordered list.
// ----------------------------------------------------------------------------
package pol_pkg;

   localparam int CAPACITY = 16;
   localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int POS_W    = 5;
   localparam int COUNT_W  = 5;
   // wide enough to compare a position against the length plus one
   localparam int CMP_W    = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

   typedef logic [IDX_W-1:0]   idx_type;
   typedef logic [CNT_W-1:0]   cnt_type;
   typedef logic signed [31:0] entry_type;

   typedef enum logic [2:0] {
      OP_INS_FRONT = 3'd0,
      OP_INS_BACK  = 3'd1,
      OP_INS_AT    = 3'd2,
      OP_DEL_FRONT = 3'd3,
      OP_DEL_BACK  = 3'd4,
      OP_DEL_AT    = 3'd5,
      OP_READ_AT   = 3'd6,
      OP_NONE      = 3'd7
   } op_type;

   typedef enum logic [1:0] {
      ST_OK     = 2'd0,
      ST_EMPTY  = 2'd1,
      ST_FULL   = 2'd2,
      ST_BADPOS = 2'd3
   } status_type;

   // command broadcast to every cell of the row
   typedef struct packed {
      logic      ins;
      logic      del;
      idx_type   slot;
      entry_type value;
   } cell_cmd_type;

endpackage

@@ hw/rtl/pol_cell.sv @@
// ----------------------------------------------------------------------------
// pol_cell
// One list slot: takes its left neighbor on insert, its right neighbor on
// delete, or the new value when it is the insert slot.
// ----------------------------------------------------------------------------
module pol_cell (
   input  logic                 clock,
   input  pol_pkg::idx_type     cell_idx,
   input  pol_pkg::cell_cmd_type cmd,
   input  pol_pkg::entry_type   left_entry,
   input  pol_pkg::entry_type   right_entry,
   output pol_pkg::entry_type   entry
);
   import pol_pkg::*;

   entry_type entry_ff;
   entry_type entry_in;

   always_comb begin
      entry_in = entry_ff;
      if (cmd.ins) begin
         if (cell_idx > cmd.slot) begin
            entry_in = left_entry;
         end else if (cell_idx == cmd.slot) begin
            entry_in = cmd.value;
         end
      end else if (cmd.del) begin
         if (cell_idx >= cmd.slot) begin
            entry_in = right_entry;
         end
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;

endmodule

@@ hw/rtl/pol_chain.sv @@
// ----------------------------------------------------------------------------
// pol_chain
// Row of list cells wired to their neighbors; all cells shift in parallel.
// ----------------------------------------------------------------------------
module pol_chain (
   input  logic                                   clock,
   input  pol_pkg::cell_cmd_type                  cmd,
   output pol_pkg::entry_type [pol_pkg::CAPACITY-1:0] entries
);
   import pol_pkg::*;

   genvar i;
   generate
      for (i = 0; i < CAPACITY; i++) begin : g_cell
         entry_type left_entry;
         entry_type right_entry;

         if (i == 0) begin : g_first
            assign left_entry = cmd.value;
         end else begin : g_left
            assign left_entry = entries[i-1];
         end

         if (i == CAPACITY - 1) begin : g_last
            assign right_entry = entries[i];
         end else begin : g_right
            assign right_entry = entries[i+1];
         end

         pol_cell u_cell (
            .clock       (clock),
            .cell_idx    (IDX_W'(i)),
            .cmd         (cmd),
            .left_entry  (left_entry),
            .right_entry (right_entry),
            .entry       (entries[i])
         );
      end
   endgenerate

endmodule

@@ hw/rtl/positional_ordered_list_top.sv @@
// ----------------------------------------------------------------------------
// positional_ordered_list_top
// Ordered list with positional insert, delete and read over a row of cells.
// Response: registered in the cycle after the item is accepted.
// Throughput: 1 item per cycle unless a stalled response holds the request;
// all cells shift in parallel; the read mux and length compare set the cycle.
// Reset: synchronous; clears the length and response valid. Cell contents
// are not cleared and are only read below the length.
// ----------------------------------------------------------------------------
module positional_ordered_list_top (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [2:0]         req_operation,
   input  logic [4:0]         req_position,
   input  logic signed [31:0] req_item_value,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [1:0]         rsp_status,
   output logic [4:0]         rsp_entry_count,
   output logic signed [31:0] rsp_read_value
);
   import pol_pkg::*;

   logic                    req_accept;
   op_type                  op;
   cnt_type                 length_ff, length_in;
   logic                    rsp_valid_ff;
   status_type              status_ff, status_in;
   logic [COUNT_W-1:0]      count_ff;
   entry_type               read_ff, read_in;
   cell_cmd_type            cmd;
   entry_type [CAPACITY-1:0] entries;

   logic [CMP_W-1:0] pos_ext, len_ext, pos_m1, len_m1;
   logic             full, empty, pos_ok_ins, pos_ok;

   assign req_stall  = rsp_valid_ff & rsp_stall;
   assign req_accept = req_valid & ~req_stall;
   assign op         = op_type'(req_operation);

   assign pos_ext    = CMP_W'(req_position);
   assign len_ext    = CMP_W'(length_ff);
   assign pos_m1     = pos_ext - CMP_W'(1);
   assign len_m1     = len_ext - CMP_W'(1);
   assign full       = (len_ext == CMP_W'(CAPACITY));
   assign empty      = (length_ff == '0);
   assign pos_ok_ins = (pos_ext != '0) && (pos_ext <= len_ext + CMP_W'(1));
   assign pos_ok     = (pos_ext != '0) && (pos_ext <= len_ext);

   always_comb begin
      cmd.ins   = 1'b0;
      cmd.del   = 1'b0;
      cmd.slot  = '0;
      cmd.value = req_item_value;
      status_in = ST_OK;
      read_in   = '0;
      length_in = length_ff;
      case (op)
         OP_INS_FRONT, OP_INS_BACK, OP_INS_AT: begin
            if (full) begin
               status_in = ST_FULL;
            end else if (op == OP_INS_AT && !pos_ok_ins) begin
               status_in = ST_BADPOS;
            end else begin
               cmd.ins = 1'b1;
               if (op == OP_INS_BACK) begin
                  cmd.slot = len_ext[IDX_W-1:0];
               end else if (op == OP_INS_AT) begin
                  cmd.slot = pos_m1[IDX_W-1:0];
               end
               length_in = length_ff + CNT_W'(1);
            end
         end
         OP_DEL_FRONT, OP_DEL_BACK, OP_DEL_AT, OP_READ_AT: begin
            if (empty) begin
               status_in = ST_EMPTY;
            end else if ((op == OP_DEL_AT || op == OP_READ_AT) && !pos_ok) begin
               status_in = ST_BADPOS;
            end else if (op == OP_READ_AT) begin
               read_in = entries[pos_m1[IDX_W-1:0]];
            end else begin
               cmd.del = 1'b1;
               if (op == OP_DEL_BACK) begin
                  cmd.slot = len_m1[IDX_W-1:0];
               end else if (op == OP_DEL_AT) begin
                  cmd.slot = pos_m1[IDX_W-1:0];
               end
               length_in = length_ff - CNT_W'(1);
            end
         end
         default: begin
         end
      endcase
      if (!req_accept) begin
         cmd.ins   = 1'b0;
         cmd.del   = 1'b0;
         length_in = length_ff;
      end
   end

   pol_chain u_chain (
      .clock   (clock),
      .cmd     (cmd),
      .entries (entries)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         length_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         length_ff <= length_in;
         if (req_accept) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         status_ff <= status_in;
         count_ff  <= COUNT_W'(CMP_W'(length_in));
         read_ff   <= read_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = status_ff;
   assign rsp_entry_count = count_ff;
   assign rsp_read_value  = read_ff;

   // length never runs past capacity
   a_len_bound: assert property (@(posedge clock) disable iff (reset)
      CMP_W'(length_ff) <= CMP_W'(CAPACITY))
      else $error("list length above capacity");

   // length only moves on an accepted item
   a_len_hold: assert property (@(posedge clock) disable iff (reset)
      !req_accept |=> $stable(length_ff))
      else $error("length changed without an item");

   // reported count matches the new length
   a_count: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> (rsp_entry_count == COUNT_W'(CMP_W'(length_ff))))
      else $error("entry count mismatch");

   // insert into a full list is refused
   a_full: assert property (@(posedge clock) disable iff (reset)
      (req_accept && full && (op == OP_INS_FRONT || op == OP_INS_BACK ||
       op == OP_INS_AT)) |=> (rsp_status == ST_FULL) && $stable(length_ff))
      else $error("insert into full list not refused");

endmodule

@@ tb/positional_ordered_list_checker.sv @@
// ----------------------------------------------------------------------------
// positional_ordered_list_checker
// Watches both channels of the positional ordered list, keeps its own copy
// of the list, predicts each response and compares it field by field.
// ----------------------------------------------------------------------------
module positional_ordered_list_checker (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_stall,
   input  logic [2:0]         req_operation,
   input  logic [4:0]         req_position,
   input  logic signed [31:0] req_item_value,
   input  logic               rsp_valid,
   input  logic               rsp_stall,
   input  logic [1:0]         rsp_status,
   input  logic [4:0]         rsp_entry_count,
   input  logic signed [31:0] rsp_read_value,
   output int                 fail_count,
   output int                 due_count,
   output int                 list_length
);
   timeunit 1ns;
   timeprecision 1ps;
   import pol_pkg::*;

   typedef struct {
      status_type status;
      logic [4:0] count;
      entry_type  value;
   } list_reply_type;

   entry_type      slots [CAPACITY];
   int             fill_len;
   list_reply_type replies_due [$];

   // applies one request to the shadow list and returns the response it gives
   function automatic list_reply_type apply_request(op_type op, logic [4:0] pos,
                                                    entry_type val);
      list_reply_type r;
      int k;
      int j;
      r.status = ST_OK;
      r.value  = '0;
      case (op)
         OP_INS_FRONT, OP_INS_BACK, OP_INS_AT: begin
            // full is tested before the position
            if (fill_len >= CAPACITY) begin
               r.status = ST_FULL;
            end else if (op == OP_INS_AT && (pos < 1 || pos > fill_len + 1)) begin
               r.status = ST_BADPOS;
            end else begin
               k = (op == OP_INS_FRONT) ? 0 :
                   (op == OP_INS_BACK) ? fill_len : int'(pos) - 1;
               for (j = fill_len; j > k; j--) slots[j] = slots[j-1];
               slots[k] = val;
               fill_len++;
            end
         end
         OP_DEL_FRONT, OP_DEL_BACK, OP_DEL_AT, OP_READ_AT: begin
            if (fill_len == 0) begin
               r.status = ST_EMPTY;
            end else if ((op == OP_DEL_AT || op == OP_READ_AT) &&
                         (pos < 1 || pos > fill_len)) begin
               r.status = ST_BADPOS;
            end else if (op == OP_READ_AT) begin
               r.value = slots[int'(pos) - 1];
            end else begin
               k = (op == OP_DEL_FRONT) ? 0 :
                   (op == OP_DEL_BACK) ? fill_len - 1 : int'(pos) - 1;
               for (j = k; j + 1 < fill_len; j++) slots[j] = slots[j+1];
               fill_len--;
            end
         end
         default: ;
      endcase
      r.count = fill_len[4:0];
      return r;
   endfunction

   always @(posedge clock) begin
      list_reply_type want;
      if (reset) begin
         fill_len = 0;
         replies_due.delete();
      end else begin
         // a response accepted now belongs to an item accepted at an earlier edge
         if (rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
            if (replies_due.size() == 0) begin
               $error("unexpected item on response channel: status=%0d count=%0d value=%0d",
                      rsp_status, rsp_entry_count, rsp_read_value);
               fail_count++;
            end else begin
               want = replies_due.pop_front();
               if (rsp_status !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, rsp_status);
                  fail_count++;
               end
               if (rsp_entry_count !== want.count) begin
                  $error("entry_count: expected %0d, got %0d", want.count, rsp_entry_count);
                  fail_count++;
               end
               if (rsp_read_value !== want.value) begin
                  $error("read_value: expected %0d, got %0d", want.value, rsp_read_value);
                  fail_count++;
               end
            end
         end
         if (req_valid === 1'b1 && req_stall === 1'b0)
            replies_due.push_back(apply_request(op_type'(req_operation), req_position,
                                                req_item_value));
      end
      due_count   = replies_due.size();
      list_length = fill_len;
   end

endmodule

@@ tb/tb_positional_ordered_list_top.sv @@
// ----------------------------------------------------------------------------
// tb_positional_ordered_list_top
// Drives directed and random list requests into the positional ordered list
// with random gaps and response back-pressure; the checker beside the block
// predicts and compares every response, this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_positional_ordered_list_top;
   timeunit 1ns;
   timeprecision 1ps;
   import pol_pkg::*;

   localparam int RANDOM_ITEMS = 1700;
   localparam int CYCLE_LIMIT  = 500000;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_stall;
   logic [2:0]         req_operation;
   logic [4:0]         req_position;
   logic signed [31:0] req_item_value;
   logic               rsp_valid;
   logic               rsp_stall;
   logic [1:0]         rsp_status;
   logic [4:0]         rsp_entry_count;
   logic signed [31:0] rsp_read_value;

   int fail_count;
   int due_count;
   int list_length;
   int req_mode;
   int cycle_count;

   positional_ordered_list_top uut (.*);

   positional_ordered_list_checker checker_i (.*);

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // mode 0: back to back, 1: any gap, 2: mostly back to back with bursts of gaps
   function automatic int pick_gap(int mode);
      if (mode == 0) return 0;
      if (mode == 1) return $urandom_range(0, 18);
      return ($urandom_range(0, 3) == 0) ? $urandom_range(1, 18) : 0;
   endfunction

   function automatic entry_type pick_value();
      case ($urandom_range(0, 15))
         0: return 32'sh8000_0000;
         1: return 32'sh7fff_ffff;
         2: return '0;
         3: return -1;
         default: return $urandom;
      endcase
   endfunction

   // ends on a falling edge with valid low for each gap cycle
   task automatic wait_gap();
      repeat (pick_gap(req_mode)) begin
         @(negedge clock);
         req_valid = 1'b0;
      end
      @(negedge clock);
   endtask

   task automatic drive_item(op_type op, logic [4:0] pos, entry_type val);
      req_valid      = 1'b1;
      req_operation  = op;
      req_position   = pos;
      req_item_value = val;
      @(posedge clock);
      while (req_stall !== 1'b0) @(posedge clock);
   endtask

   task automatic send_item(op_type op, logic [4:0] pos, entry_type val);
      wait_gap();
      drive_item(op, pos, val);
   endtask

   // response back-pressure, switching its mode every few dozen items
   initial begin
      int stall_mode;
      int taken;
      rsp_stall  = 1'b0;
      stall_mode = 1;
      taken      = 0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (taken % 64 == 0) stall_mode = $urandom_range(0, 2);
         repeat (pick_gap(stall_mode)) begin
            @(negedge clock);
            rsp_stall = 1'b1;
         end
         @(negedge clock);
         rsp_stall = 1'b0;
         @(posedge clock);
         while (rsp_valid !== 1'b1) @(posedge clock);
         taken++;
      end
   end

   initial begin
      int n;
      int kind;
      int roll;
      int len;
      op_type    op;
      logic [4:0] pos;
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_operation  = OP_INS_FRONT;
      req_position   = '0;
      req_item_value = '0;
      req_mode       = 1;
      repeat (5) @(negedge clock);
      reset = 1'b0;

      // empty list, bad insert positions, then a short list with extreme values
      send_item(OP_DEL_FRONT, 5'd0, '0);
      send_item(OP_DEL_BACK,  5'd0, '0);
      send_item(OP_DEL_AT,    5'd1, '0);
      send_item(OP_READ_AT,   5'd0, '0);
      send_item(OP_INS_AT,    5'd0, 32'sh1234_5678);
      send_item(OP_INS_AT,    5'd2, 32'sh1234_5678);
      send_item(OP_INS_AT,    5'd1, 32'sh8000_0000);
      send_item(OP_INS_FRONT, 5'd31, 32'sh7fff_ffff);
      send_item(OP_INS_BACK,  5'd0, -1);
      send_item(OP_INS_AT,    5'd4, '0);
      send_item(OP_INS_AT,    5'd17, 32'sh5555_aaaa);
      send_item(OP_READ_AT,   5'd0, '0);
      send_item(OP_READ_AT,   5'd5, '0);
      send_item(OP_READ_AT,   5'd1, '0);
      send_item(OP_READ_AT,   5'd4, '0);
      send_item(OP_READ_AT,   5'd17, '0);
      send_item(OP_NONE,      5'd3, 32'sh0bad_f00d);
      send_item(OP_DEL_AT,    5'd5, '0);
      send_item(OP_DEL_AT,    5'd2, '0);
      send_item(OP_READ_AT,   5'd2, '0);
      send_item(OP_DEL_BACK,  5'd0, '0);
      send_item(OP_DEL_FRONT, 5'd0, '0);

      // kind 0 grows toward full, 1 drains, 2 mixes, 3 is unshaped noise
      for (n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % 100 == 0) begin
            kind     = (n == 0) ? 0 : (n == 100) ? 1 : $urandom_range(0, 3);
            req_mode = $urandom_range(0, 2);
         end
         wait_gap();
         len  = list_length;
         roll = $urandom_range(0, 99);
         case (kind)
            0: op = op_type'((roll < 70) ? $urandom_range(0, 2) : $urandom_range(3, 6));
            1: op = op_type'((roll < 65) ? $urandom_range(3, 5) :
                             (roll < 85) ? 6 : $urandom_range(0, 2));
            2: op = op_type'($urandom_range(0, 6));
            default: op = op_type'($urandom_range(0, 7));
         endcase
         if (kind != 3 && $urandom_range(0, 9) != 0) begin
            if (op == OP_INS_AT) pos = 5'($urandom_range(1, len + 1));
            else if (len > 0)   pos = 5'($urandom_range(1, len));
            else                pos = 5'($urandom_range(0, 17));
         end else begin
            pos = 5'($urandom_range(0, 17));
         end
         drive_item(op, pos, pick_value());
      end

      @(negedge clock);
      req_valid = 1'b0;
      while (due_count != 0) @(negedge clock);
      repeat (4) @(negedge clock);
      if (fail_count == 0 && due_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
